// File: rtl/lfu_pkg.sv
// Shared types and constants for the LFU slot replacement block.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package lfu_pkg;

    // Fixed field widths of the stream beats and the configuration register
    localparam int ID_BITS      = 8;
    localparam int VOTE_BITS    = 10;
    localparam int OUT_IDX_BITS = 4;
    localparam int ACT_BITS     = 5;

    localparam logic [VOTE_BITS-1:0] VOTE_MAX  = '1;
    localparam logic [VOTE_BITS-1:0] VOTE_ONE  = VOTE_BITS'(1);
    localparam logic [ACT_BITS-1:0]  ACT_RESET = ACT_BITS'(16);

    // Register map: byte address bit 2 selects the register
    localparam logic REG_ACTIVE_SLOTS = 1'b0;

    typedef enum logic [1:0] {
        OUT_HIT     = 2'd0,
        OUT_FILL    = 2'd1,
        OUT_REPLACE = 2'd2
    } t_outcome;

    // Controller to datapath
    typedef struct packed {
        logic load_id;
        logic compare;
        logic hit_update;
        logic fill;
        logic scan_start;
        logic scan_step;
        logic replace;
        logic out_load;
    } t_lfu_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic room;
        logic scan_end;
    } t_lfu_sts;

endpackage

`default_nettype wire

// File: rtl/lfu_slot_replacement.sv
// One item at a time; hit or fill passes the match, decide and done states to the output beat.
// Replace: after decide, a victim scan walks one slot per cycle, then the replace and done states.
// The output beat sits in its own register, so a waiting result stalls only the next
// result, not the table update. Reset (synchronous, active low) empties the table and
// sets active_slots to 16; slot contents are not cleared and need no clearing pass.
// Top level of the LFU slot replacement block; depends on lfu_pkg, lfu_ctrl, lfu_datapath.
`default_nettype none

module lfu_slot_replacement #(
    parameter int SLOTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] candidate_id
    // Output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] outcome, [5:2] slot_index,
                                        // [15:6] vote_count, [23:16] evicted_id
    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lfu_pkg::*;

    t_lfu_cmd                cmd;
    t_lfu_sts                sts;
    logic [ACT_BITS-1:0]     r_active_slots;
    logic [1:0]              outcome;
    logic [OUT_IDX_BITS-1:0] slot_index;
    logic [VOTE_BITS-1:0]    vote_count;
    logic [ID_BITS-1:0]      evicted_id;

    // Configuration: one register, written in the access phase, never stalled
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= ACT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_ACTIVE_SLOTS)) begin
            r_active_slots <= pwdata[ACT_BITS-1:0];
        end
    end

    // Read back the register; the unmapped word reads as zero
    assign prdata = (paddr[2] == REG_ACTIVE_SLOTS) ? {{(32-ACT_BITS){1'b0}}, r_active_slots}
                                                    : '0;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lfu_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cand_id      (s_axis_tdata[ID_BITS-1:0]),
        .i_active_slots (r_active_slots),
        .o_outcome      (outcome),
        .o_slot_index   (slot_index),
        .o_vote_count   (vote_count),
        .o_evicted_id   (evicted_id)
    );

    // Pack the output beat, first field lowest
    assign m_axis_tdata = {evicted_id, vote_count, slot_index, outcome};

endmodule

`default_nettype wire

// File: rtl/lfu_ctrl.sv
// Sequencing state machine of the LFU slot replacement block.
// Depends on lfu_pkg for the command and status structs.
`default_nettype none

module lfu_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output lfu_pkg::t_lfu_cmd o_cmd,
    input  lfu_pkg::t_lfu_sts i_sts
);
    import lfu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_SCAN,
        S_REPLACE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_id = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.compare = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (i_sts.hit) begin
                    o_cmd.hit_update = 1'b1;
                    n_state          = S_DONE;
                end else if (i_sts.room) begin
                    o_cmd.fill = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_REPLACE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_REPLACE: begin
                o_cmd.replace = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/lfu_datapath.sv
// Slot table, id compare, victim scan and result registers of the LFU block.
// Depends on lfu_pkg; driven by lfu_ctrl through command and status structs.
`default_nettype none

module lfu_datapath #(
    parameter int SLOTS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  lfu_pkg::t_lfu_cmd            i_cmd,
    output lfu_pkg::t_lfu_sts            o_sts,
    input  wire [lfu_pkg::ID_BITS-1:0]   i_cand_id,
    input  wire [lfu_pkg::ACT_BITS-1:0]  i_active_slots,
    output logic [1:0]                   o_outcome,
    output logic [lfu_pkg::OUT_IDX_BITS-1:0] o_slot_index,
    output logic [lfu_pkg::VOTE_BITS-1:0]    o_vote_count,
    output logic [lfu_pkg::ID_BITS-1:0]      o_evicted_id
);
    import lfu_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > ACT_BITS) ? CNT_W : ACT_BITS;

    // Slot table
    logic [ID_BITS-1:0]   r_id    [SLOTS];
    logic [VOTE_BITS-1:0] r_votes [SLOTS];
    logic [SLOT_W-1:0]    r_rank  [SLOTS];
    logic [CNT_W-1:0]     r_filled;

    logic [ID_BITS-1:0]   r_cand;
    logic [SLOTS-1:0]     r_match;

    // Victim scan
    logic [CNT_W-1:0]     r_scan_ptr;
    logic [SLOT_W-1:0]    r_best_idx;
    logic [VOTE_BITS-1:0] r_best_votes;
    logic [SLOT_W-1:0]    r_best_rank;
    logic [ID_BITS-1:0]   r_best_id;

    // Pending result and output beat
    t_outcome             r_res_outcome;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [VOTE_BITS-1:0] r_res_votes;
    logic [ID_BITS-1:0]   r_res_evicted;
    logic [1:0]           r_out_outcome;
    logic [OUT_IDX_BITS-1:0] r_out_slot;
    logic [VOTE_BITS-1:0] r_out_votes;
    logic [ID_BITS-1:0]   r_out_evicted;

    logic [ACT_BITS-1:0]  lim;
    logic [SLOT_W-1:0]    hit_idx;
    logic [VOTE_BITS-1:0] hit_old;
    logic [VOTE_BITS-1:0] hit_new;
    logic [SLOT_W-1:0]    fill_idx;
    logic [SLOT_W-1:0]    scan_idx;
    logic                 scan_valid;
    logic                 scan_better;
    logic [SLOT_W-1:0]    new_rank;
    logic [CNT_W-1:0]     filled_m1;
    logic [SLOT_W+OUT_IDX_BITS-1:0] slot_ext;

    // Zero acts as one; values above the table size are capped by the room check
    assign lim = (i_active_slots == '0) ? ACT_BITS'(1) : i_active_slots;

    assign o_sts.hit      = |r_match;
    assign o_sts.room     = (CMP_W'(r_filled) < CMP_W'(lim)) && (r_filled < CNT_W'(SLOTS));
    assign o_sts.scan_end = (r_scan_ptr == CNT_W'(SLOTS));

    // Ids held in valid slots are distinct, so at most one bit of the match vector is set
    always_comb begin
        hit_idx = '0;
        hit_old = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_match[i]) begin
                hit_idx = hit_idx | SLOT_W'(i);
                hit_old = hit_old | r_votes[i];
            end
        end
    end

    assign hit_new     = (hit_old == VOTE_MAX) ? hit_old : hit_old + VOTE_ONE;
    assign fill_idx    = r_filled[SLOT_W-1:0];
    assign scan_idx    = r_scan_ptr[SLOT_W-1:0];
    assign scan_valid  = (r_scan_ptr < r_filled);
    assign scan_better = {r_votes[scan_idx], r_rank[scan_idx]} < {r_best_votes, r_best_rank};
    assign filled_m1   = r_filled - CNT_W'(1);
    assign new_rank    = filled_m1[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (i_cmd.fill) begin
            r_filled <= r_filled + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_id) begin
            r_cand <= i_cand_id;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_match[i] <= (CNT_W'(i) < r_filled) && (r_id[i] == r_cand);
            end
        end
    end

    // Table write-back
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i_cmd.hit_update && r_match[i]) begin
                r_votes[i] <= hit_new;
            end
            if (i_cmd.fill && (SLOT_W'(i) == fill_idx)) begin
                r_id[i]    <= r_cand;
                r_votes[i] <= VOTE_ONE;
                r_rank[i]  <= fill_idx;
            end
            if (i_cmd.replace) begin
                if ((CNT_W'(i) < r_filled) && (r_rank[i] > r_best_rank)) begin
                    r_rank[i] <= r_rank[i] - SLOT_W'(1);
                end
                if (SLOT_W'(i) == r_best_idx) begin
                    r_id[i]    <= r_cand;
                    r_votes[i] <= VOTE_ONE;
                    r_rank[i]  <= new_rank;
                end
            end
        end
    end

    // Walk the slots one a cycle, keep the fewest votes, oldest first on a tie
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_ptr   <= CNT_W'(1);
            r_best_idx   <= '0;
            r_best_votes <= r_votes[0];
            r_best_rank  <= r_rank[0];
            r_best_id    <= r_id[0];
        end else if (i_cmd.scan_step) begin
            r_scan_ptr <= r_scan_ptr + CNT_W'(1);
            if (scan_valid && scan_better) begin
                r_best_idx   <= scan_idx;
                r_best_votes <= r_votes[scan_idx];
                r_best_rank  <= r_rank[scan_idx];
                r_best_id    <= r_id[scan_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.hit_update) begin
            r_res_outcome <= OUT_HIT;
            r_res_slot    <= hit_idx;
            r_res_votes   <= hit_new;
            r_res_evicted <= '0;
        end else if (i_cmd.fill) begin
            r_res_outcome <= OUT_FILL;
            r_res_slot    <= fill_idx;
            r_res_votes   <= VOTE_ONE;
            r_res_evicted <= '0;
        end else if (i_cmd.replace) begin
            r_res_outcome <= OUT_REPLACE;
            r_res_slot    <= r_best_idx;
            r_res_votes   <= VOTE_ONE;
            r_res_evicted <= r_best_id;
        end
    end

    assign slot_ext = {{OUT_IDX_BITS{1'b0}}, r_res_slot};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_outcome <= r_res_outcome;
            r_out_slot    <= slot_ext[OUT_IDX_BITS-1:0];
            r_out_votes   <= r_res_votes;
            r_out_evicted <= r_res_evicted;
        end
    end

    assign o_outcome    = r_out_outcome;
    assign o_slot_index = r_out_slot;
    assign o_vote_count = r_out_votes;
    assign o_evicted_id = r_out_evicted;

endmodule

`default_nettype wire

// File: rtl/lfu_checker.sv
// Port-level checks for lfu_slot_replacement, attached by the bind at the end.
// Depends on lfu_pkg for the outcome codes.
`default_nettype none

module lfu_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);
    import lfu_pkg::*;

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");

    // One item at a time: no input beat right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // Only a replacement reports an evicted id
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] != OUT_REPLACE)) |-> (m_axis_tdata[23:16] == 8'd0))
        else $error("evicted id set without a replacement");

    // A new entry starts with one vote
    a_new_vote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] != OUT_HIT)) |-> (m_axis_tdata[15:6] == 10'd1))
        else $error("new entry without exactly one vote");

endmodule

bind lfu_slot_replacement lfu_checker u_lfu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
